>>> rtl/core/srrip_pkg.sv
// ----------------------------------------------------------------------------
// SRRIP victim select package
// Shared sizes, action codes and the queued request type.
// ----------------------------------------------------------------------------
package srrip_pkg;

  localparam int unsigned WAYS        = 16;
  localparam int unsigned SETS        = 1024;
  localparam int unsigned WAY_W       = 4;
  localparam int unsigned SET_W       = 10;
  localparam int unsigned RRPV_W      = 2;
  localparam int unsigned ROW_W       = WAYS * (RRPV_W + 2);
  localparam logic [RRPV_W-1:0] RRPV_MAX = 2'd3;
  localparam logic [2:0] RETRY_LIMIT  = 3'd5;

  localparam logic [1:0] ACT_FIND  = 2'd0;
  localparam logic [1:0] ACT_HIT   = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;
  localparam logic [1:0] ACT_MARKS = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [SET_W-1:0] set_index;
    logic [WAY_W-1:0] way;
    logic             sector_mark;
    logic             protect_mark;
  } item_t;

endpackage

>>> rtl/core/srrip_front.sv
// ----------------------------------------------------------------------------
// SRRIP front queue
// Accepts commands into a two-entry queue ahead of the set engine.
// ----------------------------------------------------------------------------
module srrip_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  srrip_pkg::item_t push_item_i,
  output logic          full_o,
  output logic          head_valid_o,
  output srrip_pkg::item_t head_item_o,
  input  logic          pop_i
);

  srrip_pkg::item_t buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_item_o  = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/core/srrip_back.sv
// ----------------------------------------------------------------------------
// SRRIP set engine
// Clears the set memory after reset, then runs one command at a time as a
// read-modify-write of one set row, ageing and retrying for victim searches.
// ----------------------------------------------------------------------------
module srrip_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  srrip_pkg::item_t head_item_i,
  output logic          pop_o,
  output logic          clearing_o,
  output logic          done_o,
  output logic [srrip_pkg::WAY_W-1:0] victim_way_o,
  output logic          victim_valid_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [srrip_pkg::SET_W-1:0] clr_q, clr_d;
  logic [2:0] tries_q, tries_d;
  srrip_pkg::item_t item_q;

  logic [srrip_pkg::ROW_W-1:0] mem [srrip_pkg::SETS];
  logic [srrip_pkg::ROW_W-1:0] rd_q;

  logic [srrip_pkg::WAYS-1:0][srrip_pkg::RRPV_W-1:0] rrpv_q, rrpv_d;
  logic [srrip_pkg::WAYS-1:0] sec_q, sec_d, prot_q, prot_d;

  logic done_d, vvalid_d;
  logic [srrip_pkg::WAY_W-1:0] vway_d;
  logic done_q, vvalid_q;
  logic [srrip_pkg::WAY_W-1:0] vway_q;

  logic found;
  logic [srrip_pkg::WAY_W-1:0] cand;
  logic we;
  logic [srrip_pkg::SET_W-1:0] wr_addr;
  logic [srrip_pkg::ROW_W-1:0] wr_row;

  assign pop_o      = (state_q == S_IDLE) && head_valid_i;
  assign clearing_o = (state_q == S_CLR);
  assign done_o     = done_q;
  assign victim_way_o   = vway_q;
  assign victim_valid_o = vvalid_q;

  // lowest non-sector way at the maximum value
  always_comb begin
    found = 1'b0;
    cand  = '0;
    for (int w = srrip_pkg::WAYS - 1; w >= 0; w--) begin
      if (rrpv_q[w] == srrip_pkg::RRPV_MAX && !sec_q[w]) begin
        found = 1'b1;
        cand  = srrip_pkg::WAY_W'(w);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    tries_d  = tries_q;
    rrpv_d   = rrpv_q;
    sec_d    = sec_q;
    prot_d   = prot_q;
    done_d   = 1'b0;
    vvalid_d = vvalid_q;
    vway_d   = vway_q;
    we       = 1'b0;
    wr_addr  = item_q.set_index;
    wr_row   = {prot_q, sec_q, rrpv_q};
    case (state_q)
      S_CLR: begin
        we      = 1'b1;
        wr_addr = clr_q;
        wr_row  = {{(2 * srrip_pkg::WAYS){1'b0}}, {srrip_pkg::WAYS{srrip_pkg::RRPV_MAX}}};
        clr_d   = clr_q + 1'b1;
        if (clr_q == srrip_pkg::SET_W'(srrip_pkg::SETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid_i) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        {prot_d, sec_d, rrpv_d} = rd_q;
        tries_d = 3'd0;
        state_d = S_WB;
        case (item_q.action)
          srrip_pkg::ACT_FIND: begin
            if (&rd_q[srrip_pkg::WAYS*srrip_pkg::RRPV_W +: srrip_pkg::WAYS]) begin
              // every way a sector line: report no victim, leave the row alone
              done_d   = 1'b1;
              vvalid_d = 1'b0;
              vway_d   = '0;
              state_d  = S_IDLE;
            end else begin
              state_d = S_RUN;
            end
          end
          srrip_pkg::ACT_HIT:  rrpv_d[item_q.way] = '0;
          srrip_pkg::ACT_FILL: rrpv_d[item_q.way] = srrip_pkg::RRPV_MAX - 1'b1;
          srrip_pkg::ACT_MARKS: begin
            sec_d[item_q.way]  = item_q.sector_mark;
            prot_d[item_q.way] = item_q.protect_mark;
          end
          default: state_d = S_WB;
        endcase
      end
      S_RUN: begin
        if (!found) begin
          for (int w = 0; w < srrip_pkg::WAYS; w++) begin
            if (rrpv_q[w] != srrip_pkg::RRPV_MAX) rrpv_d[w] = rrpv_q[w] + 1'b1;
          end
        end else if (prot_q[cand] && tries_q < srrip_pkg::RETRY_LIMIT) begin
          // demote the protected candidate and age the rest
          for (int w = 0; w < srrip_pkg::WAYS; w++) begin
            if (srrip_pkg::WAY_W'(w) == cand) begin
              rrpv_d[w] = rrpv_q[w] - 1'b1;
            end else if (rrpv_q[w] != srrip_pkg::RRPV_MAX) begin
              rrpv_d[w] = rrpv_q[w] + 1'b1;
            end
          end
          tries_d = tries_q + 1'b1;
        end else begin
          done_d   = 1'b1;
          vvalid_d = 1'b1;
          vway_d   = cand;
          state_d  = S_WB;
        end
      end
      S_WB: begin
        we      = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      tries_q  <= 3'd0;
      done_q   <= 1'b0;
      vvalid_q <= 1'b0;
      vway_q   <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      tries_q  <= tries_d;
      done_q   <= done_d;
      vvalid_q <= vvalid_d;
      vway_q   <= vway_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rrpv_q <= rrpv_d;
    sec_q  <= sec_d;
    prot_q <= prot_d;
    if (pop_o) begin
      item_q <= head_item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_row;
    end
    if (pop_o) begin
      rd_q <= mem[head_item_i.set_index];
    end
  end

endmodule

>>> rtl/core/srrip_victim_select_with_pinned_lines.sv
// A victim search strobes done_o after its ageing passes and demotion retries,
// or straight from the row read when every way is a sector line; hit, fill and
// mark writes return nothing. One set row read-modify-write at a time; the
// two-entry queue takes commands meanwhile.
// Reset clears the set memory in a pass over all 1024 sets; busy is high meanwhile.
// Results appear for one cycle on done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
// SRRIP victim select with pinned lines
// Command queue in front of a set engine that keeps per-way RRPV and marks.
// ----------------------------------------------------------------------------
module srrip_victim_select_with_pinned_lines (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] action_i,
  input  logic [9:0] set_index_i,
  input  logic [3:0] way_i,
  input  logic       sector_mark_i,
  input  logic       protect_mark_i,
  output logic       done_o,
  output logic [3:0] victim_way_o,
  output logic       victim_valid_o
);

  srrip_pkg::item_t in_item, head_item;
  logic full, head_valid, pop, clearing, push;

  assign in_item = '{action: action_i, set_index: set_index_i, way: way_i,
                     sector_mark: sector_mark_i, protect_mark: protect_mark_i};
  assign busy = full | clearing;
  assign push = start & ~busy;

  srrip_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .push_item_i(in_item), .full_o(full),
    .head_valid_o(head_valid), .head_item_o(head_item), .pop_i(pop)
  );

  srrip_back u_back (
    .clk_i, .rst_ni,
    .head_valid_i(head_valid), .head_item_i(head_item), .pop_o(pop),
    .clearing_o(clearing), .done_o, .victim_way_o, .victim_valid_o
  );

`ifndef NO_ASSERTIONS
  a_no_done_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !done_o) else $error("result during clear");
  a_done_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back results");
  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !pop) else $error("dequeue during clear");
`endif

endmodule

>>> tb/srrip_victim_select_with_pinned_lines_tb.sv
// ----------------------------------------------------------------------------
// SRRIP victim select testbench
// Drives hit, fill, mark and victim-search commands through the start/busy
// handshake, predicts each victim from a local copy of the per-way RRPV and
// mark state, and compares every done_o result against the oldest prediction.
// ----------------------------------------------------------------------------
module srrip_victim_select_with_pinned_lines_tb;
  import srrip_pkg::*;

  typedef struct {
    item_t cmd;
    bit    drain_first;
    bit    no_gaps;
  } pending_t;

  typedef struct {
    logic [WAY_W-1:0] way;
    logic             valid;
  } victim_t;

  localparam int NUM_RANDOM = 1230;
  localparam int WATCHDOG   = 6000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       action_i = ACT_HIT;
  logic [9:0]       set_index_i = '0;
  logic [3:0]       way_i = '0;
  logic             sector_mark_i = 1'b0;
  logic             protect_mark_i = 1'b0;
  logic             done_o;
  logic [3:0]       victim_way_o;
  logic             victim_valid_o;

  logic [RRPV_W-1:0] rrpv_q [SETS][WAYS];
  bit                sector_q [SETS][WAYS];
  bit                protect_q [SETS][WAYS];

  pending_t pending_q[$];
  victim_t  victims_q[$];
  int       mismatches = 0;
  int       idle_cnt = 0;
  int       quiet_cnt = 0;
  bit       took = 1'b0;
  bit       moved;

  srrip_victim_select_with_pinned_lines u_dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic int first_victim(int s);
    for (int w = 0; w < WAYS; w++)
      if (rrpv_q[s][w] == RRPV_MAX && !sector_q[s][w]) return w;
    return WAYS;
  endfunction

  function automatic int age_and_search(int s);
    int v;
    v = first_victim(s);
    for (int pass = 0; v == WAYS && pass <= RRPV_MAX; pass++) begin
      for (int w = 0; w < WAYS; w++)
        if (rrpv_q[s][w] < RRPV_MAX) rrpv_q[s][w]++;
      v = first_victim(s);
    end
    return v;
  endfunction

  function automatic victim_t select_victim(int s);
    victim_t r;
    bit      any;
    int      v;
    any = 1'b0;
    for (int w = 0; w < WAYS; w++)
      if (!sector_q[s][w]) any = 1'b1;
    if (!any) begin
      r.way = '0;
      r.valid = 1'b0;
      return r;
    end
    v = age_and_search(s);
    for (int t = 0; t < RETRY_LIMIT && v < WAYS; t++) begin
      if (!protect_q[s][v]) break;
      // demote the protected candidate, age the rest
      rrpv_q[s][v]--;
      for (int w = 0; w < WAYS; w++)
        if (w != v && rrpv_q[s][w] < RRPV_MAX) rrpv_q[s][w]++;
      v = age_and_search(s);
    end
    if (v >= WAYS) v = 0;
    r.way = v[WAY_W-1:0];
    r.valid = 1'b1;
    return r;
  endfunction

  function automatic void apply_cmd(item_t c);
    int s;
    s = c.set_index % SETS;
    case (c.action)
      ACT_FIND: victims_q.push_back(select_victim(s));
      ACT_HIT: rrpv_q[s][c.way] = '0;
      ACT_FILL: rrpv_q[s][c.way] = RRPV_MAX - 1'b1;
      default: begin
        sector_q[s][c.way] = c.sector_mark;
        protect_q[s][c.way] = c.protect_mark;
      end
    endcase
  endfunction

  task automatic queue_cmd(logic [1:0] act, int s, int w, bit sec, bit prot,
                           bit drain, bit quiet);
    pending_t p;
    p.cmd.action = act;
    p.cmd.set_index = s[SET_W-1:0];
    p.cmd.way = w[WAY_W-1:0];
    p.cmd.sector_mark = sec;
    p.cmd.protect_mark = prot;
    p.drain_first = drain;
    p.no_gaps = quiet;
    pending_q.push_back(p);
  endtask

  // check results, then record the transfer
  always @(posedge clk_i) begin
    moved = 1'b0;
    if (rst_ni && done_o) begin
      moved = 1'b1;
      if (victims_q.size() == 0) begin
        $display("%0t: unexpected result way=%0d valid=%0d", $time,
                 victim_way_o, victim_valid_o);
        mismatches++;
      end else begin
        victim_t e;
        e = victims_q.pop_front();
        if (victim_valid_o !== e.valid) begin
          $display("%0t: victim_valid expected %0d actual %0d", $time,
                   e.valid, victim_valid_o);
          mismatches++;
        end
        if (victim_way_o !== e.way) begin
          $display("%0t: victim_way expected %0d actual %0d", $time,
                   e.way, victim_way_o);
          mismatches++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      apply_cmd({action_i, set_index_i, way_i, sector_mark_i, protect_mark_i});
      moved = 1'b1;
    end
    took <= rst_ni && start && !busy;
    quiet_cnt <= moved ? 0 : quiet_cnt + 1;
    if (quiet_cnt >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !(start && !took)) begin
      if (idle_cnt > 0) begin
        start <= 1'b0;
        idle_cnt <= idle_cnt - 1;
      end else if (pending_q.size() > 0 &&
                   (!pending_q[0].drain_first || victims_q.size() == 0)) begin
        pending_t p;
        p = pending_q.pop_front();
        start <= 1'b1;
        action_i <= p.cmd.action;
        set_index_i <= p.cmd.set_index;
        way_i <= p.cmd.way;
        sector_mark_i <= p.cmd.sector_mark;
        protect_mark_i <= p.cmd.protect_mark;
        if (!p.no_gaps && $urandom_range(3) == 0) idle_cnt <= $urandom_range(1, 11);
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    int hot [8];
    int s, w;
    for (int i = 0; i < SETS; i++)
      for (int j = 0; j < WAYS; j++) begin
        rrpv_q[i][j] = RRPV_MAX;
        sector_q[i][j] = 1'b0;
        protect_q[i][j] = 1'b0;
      end
    for (int i = 0; i < 8; i++) hot[i] = $urandom_range(SETS - 1);

    // fresh set, then hit/fill ordering
    queue_cmd(ACT_FIND, 0, 0, 0, 0, 0, 0);
    queue_cmd(ACT_HIT, 0, 0, 0, 0, 0, 0);
    queue_cmd(ACT_FILL, 0, 1, 0, 0, 0, 0);
    queue_cmd(ACT_FIND, 0, 0, 0, 0, 0, 0);
    queue_cmd(ACT_HIT, 1023, 15, 0, 0, 0, 0);
    queue_cmd(ACT_FIND, 1023, 15, 1, 1, 0, 0);
    // every way a sector line: no victim
    for (int i = 0; i < WAYS; i++) queue_cmd(ACT_MARKS, 5, i, 1, i[0], 0, 0);
    queue_cmd(ACT_FIND, 5, 0, 0, 0, 0, 0);
    // protected candidate runs out of retries; hold until all results are back
    queue_cmd(ACT_MARKS, 7, 0, 0, 1, 1, 0);
    queue_cmd(ACT_MARKS, 7, 1, 0, 1, 0, 0);
    queue_cmd(ACT_FIND, 7, 0, 0, 0, 0, 0);
    queue_cmd(ACT_FIND, 7, 0, 0, 0, 0, 0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      int r;
      bit quiet;
      quiet = (i >= NUM_RANDOM - 150);
      s = ($urandom_range(9) == 0) ? $urandom_range(SETS - 1) : hot[$urandom_range(7)];
      w = $urandom_range(WAYS - 1);
      r = $urandom_range(99);
      if (r < 35)
        queue_cmd(ACT_FIND, s, w, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  i == NUM_RANDOM / 2, quiet);
      else if (r < 60)
        queue_cmd(ACT_HIT, s, w, 1'($urandom_range(1)), 1'($urandom_range(1)), 0,
                  quiet);
      else if (r < 82)
        queue_cmd(ACT_FILL, s, w, 1'($urandom_range(1)), 1'($urandom_range(1)), 0,
                  quiet);
      else
        queue_cmd(ACT_MARKS, s, w, $urandom_range(3) == 0, $urandom_range(2) == 0,
                  0, quiet);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && !start && victims_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/srrip_pkg.sv
rtl/core/srrip_front.sv
rtl/core/srrip_back.sv
rtl/core/srrip_victim_select_with_pinned_lines.sv
tb/srrip_victim_select_with_pinned_lines_tb.sv
